// File: sv/fixed_block_free_list_allocator_assert.svh
// Assertion macros for the fixed block free list allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define FBFL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define FBFL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FBFL_ASSERT_IMP(label, ante, cons, msg)
`define FBFL_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: sv/fbfl_pkg.sv
// Shared types and constants of the fixed block free list allocator.
`timescale 1ns / 1ps
package fbfl_pkg;
	localparam int MAX_CHUNK_BLOCKS = 16;
	localparam int MAX_CHUNK_COUNT = 16;
	localparam int HANDLE_W = 8;
	localparam int LINK_W = HANDLE_W + 1;
	localparam int LINK_DEPTH = 1 << HANDLE_W;
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CHUNK_CNT_W = 5;
	localparam int NCELL = MAX_CHUNK_BLOCKS;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 1'b1;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t command;
		logic handle_present;
		logic [HANDLE_W-1:0] release_handle;
	} req_t;

	typedef struct packed {
		logic granted;
		logic [HANDLE_W-1:0] block_handle;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [HANDLE_W-1:0] handle;
	} slot_t;
endpackage

// File: sv/fixed_block_free_list_allocator.sv
// Top level of the fixed block free list allocator.
// A release, or an allocation that fails, gives its result in the cycle after acceptance.
// An allocation from a non-empty list passes through ST_POP, where the registered link memory read becomes the head.
// An allocation that adds a chunk stays in ST_FILL while it links the blocks of the chunk, then gives its result.
// The next request is accepted at the edge that takes a result, so a new request waits for the last one's result.
// Results cannot be stalled; reset empties the list, zeroes the chunk count, sets both registers to 16.
`timescale 1ns / 1ps
`include "fixed_block_free_list_allocator_assert.svh"
module fixed_block_free_list_allocator import fbfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t request,
	output logic busy,
	output logic done,
	output rsp_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_FILL
	} state_t;

	state_t state_q;
	logic [LINK_W-1:0] head_q;
	logic [CHUNK_CNT_W-1:0] chunks_q;
	logic [CFG_W-1:0] bpc_q;
	logic [CFG_W-1:0] limit_q;
	logic done_q;
	rsp_t result_q;
	logic [LINK_W-1:0] link_mem [LINK_DEPTH];
	logic [LINK_W-1:0] link_rd_q;

	logic accept;
	logic head_empty;
	logic [CFG_W-1:0] eff_bpc;
	logic [CFG_W-1:0] eff_limit;
	logic can_add;
	logic [CHUNK_CNT_W+CFG_W-1:0] base_prod;
	logic chain_load;
	slot_t chain_head;
	logic chain_more;
	logic mem_we;
	logic [HANDLE_W-1:0] mem_waddr;

	assign accept = start && (state_q == ST_IDLE);
	assign head_empty = head_q[LINK_W-1];

	always_comb begin
		if (bpc_q == '0) begin
			eff_bpc = CFG_W'(1);
		end else if (bpc_q > CFG_W'(MAX_CHUNK_BLOCKS)) begin
			eff_bpc = CFG_W'(MAX_CHUNK_BLOCKS);
		end else begin
			eff_bpc = bpc_q;
		end
		if (limit_q > CFG_W'(MAX_CHUNK_COUNT)) begin
			eff_limit = CFG_W'(MAX_CHUNK_COUNT);
		end else begin
			eff_limit = limit_q;
		end
	end

	assign can_add = CFG_W'(chunks_q) < eff_limit;
	assign base_prod = (CHUNK_CNT_W+CFG_W)'(chunks_q) * (CHUNK_CNT_W+CFG_W)'(eff_bpc);
	assign chain_load = accept && (request.command == CMD_ALLOC) && head_empty && can_add;

	fbfl_chain u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.load(chain_load),
		.shift(state_q == ST_FILL),
		.base(base_prod[HANDLE_W-1:0]),
		.count(eff_bpc),
		.head(chain_head),
		.more(chain_more)
	);

	assign mem_we = (state_q == ST_FILL) ||
		(accept && (request.command == CMD_RELEASE) && request.handle_present);
	assign mem_waddr = (state_q == ST_FILL) ? chain_head.handle : request.release_handle;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= head_q;
		end
		link_rd_q <= link_mem[head_q[HANDLE_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= {1'b1, {HANDLE_W{1'b0}}};
			chunks_q <= '0;
			bpc_q <= CFG_W'(16);
			limit_q <= CFG_W'(16);
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CHUNK_BLOCKS: bpc_q <= cfg_data;
					REG_CHUNK_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (request.command == CMD_ALLOC) begin
							if (!head_empty) begin
								result_q.block_handle <= head_q[HANDLE_W-1:0];
								state_q <= ST_POP;
							end else if (can_add) begin
								chunks_q <= chunks_q + CHUNK_CNT_W'(1);
								state_q <= ST_FILL;
							end else begin
								done_q <= 1'b1;
								result_q.granted <= 1'b0;
								result_q.block_handle <= '0;
							end
						end else begin
							done_q <= 1'b1;
							result_q.granted <= 1'b1;
							if (request.handle_present) begin
								head_q <= {1'b0, request.release_handle};
								result_q.block_handle <= request.release_handle;
							end else begin
								result_q.block_handle <= '0;
							end
						end
					end
				end
				ST_POP: begin
					head_q <= link_rd_q;
					done_q <= 1'b1;
					result_q.granted <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					if (chain_more) begin
						head_q <= {1'b0, chain_head.handle};
					end else begin
						done_q <= 1'b1;
						result_q.granted <= 1'b1;
						result_q.block_handle <= chain_head.handle;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;
	assign cfg_ready = 1'b1;

	`FBFL_ASSERT_IMP(a_fill_has_handle, state_q == ST_FILL, chain_head.valid, "Refill step without a pending handle.")
	`FBFL_ASSERT_IMP(a_fail_only_exhausted, done_q && !result_q.granted, head_empty && !can_add, "Allocation refused while space remained.")
	`FBFL_ASSERT_NXT(a_pop_completes, state_q == ST_POP, state_q == ST_IDLE && done_q, "Pop did not complete in one cycle.")
	`FBFL_ASSERT_NXT(a_release_links, accept && request.command == CMD_RELEASE && request.handle_present, !head_q[LINK_W-1] && done_q, "Release did not make the list non-empty.")
	`FBFL_ASSERT_IMP(a_chunks_bounded, 1'b1, chunks_q <= CHUNK_CNT_W'(MAX_CHUNK_COUNT), "Chunk count beyond its maximum.")
endmodule

// File: sv/fbfl_cell.sv
// One cell of the chunk refill chain, holding one pending block handle.
`timescale 1ns / 1ps
module fbfl_cell import fbfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic shift,
	input slot_t load_slot,
	input slot_t nbr,
	output slot_t slot
);
	logic valid_q;
	logic [HANDLE_W-1:0] handle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_slot.valid;
		end else if (shift) begin
			valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			handle_q <= load_slot.handle;
		end else if (shift) begin
			handle_q <= nbr.handle;
		end
	end

	assign slot.valid = valid_q;
	assign slot.handle = handle_q;
endmodule

// File: sv/fbfl_chain.sv
// Row of refill cells that feeds the handles of a new chunk to the list, lowest slot first.
`timescale 1ns / 1ps
module fbfl_chain import fbfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic shift,
	input logic [HANDLE_W-1:0] base,
	input logic [CFG_W-1:0] count,
	output slot_t head,
	output logic more
);
	slot_t slots [NCELL+1];

	assign slots[NCELL] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		slot_t init;
		assign init.valid = CFG_W'(i) < count;
		assign init.handle = base + HANDLE_W'(i);
		fbfl_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.load(load),
			.shift(shift),
			.load_slot(init),
			.nbr(slots[i+1]),
			.slot(slots[i])
		);
	end

	assign head = slots[0];
	assign more = slots[1].valid;
endmodule

// File: bench/fixed_block_free_list_allocator_tb.sv
// Self-checking testbench for the fixed block free list allocator, directed and random requests.
`timescale 1ns / 1ps
module fixed_block_free_list_allocator_tb;
	import fbfl_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = MAX_CHUNK_BLOCKS + 4;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 192;

	class alloc_scoreboard;
		logic [LINK_W-1:0] next_link [LINK_DEPTH];
		logic [LINK_W-1:0] head;
		int unsigned chunks;
		logic [CFG_W-1:0] blocks_reg;
		logic [CFG_W-1:0] limit_reg;
		rsp_t grants_due [$];
		logic [HANDLE_W-1:0] held [$];
		int unsigned errors;
		int unsigned requests;
		int unsigned failures;
		int unsigned writes;

		function new();
			foreach (next_link[i]) next_link[i] = '0;
			head = LINK_W'(LINK_DEPTH);
			chunks = 0;
			blocks_reg = CFG_W'(16);
			limit_reg = CFG_W'(16);
			errors = 0;
			requests = 0;
			failures = 0;
			writes = 0;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
			writes++;
			case (idx)
				REG_CHUNK_BLOCKS: blocks_reg = data;
				REG_CHUNK_LIMIT: limit_reg = data;
				default: ;
			endcase
		endfunction

		function void note_request(input req_t r);
			int unsigned lim;
			int unsigned bpc;
			int unsigned base;
			logic [HANDLE_W-1:0] h;
			rsp_t e;
			requests++;
			e = '0;
			if (r.command == CMD_ALLOC) begin
				lim = (limit_reg > MAX_CHUNK_COUNT) ? MAX_CHUNK_COUNT : limit_reg;
				if (blocks_reg == 0) begin
					bpc = 1;
				end else begin
					bpc = (blocks_reg > MAX_CHUNK_BLOCKS) ? MAX_CHUNK_BLOCKS : blocks_reg;
				end
				// An empty list is refilled lazily, highest slot of the new chunk on top.
				if (head[HANDLE_W] && chunks < lim) begin
					base = chunks * bpc;
					for (int unsigned i = 0; i < bpc; i++) begin
						h = HANDLE_W'(base + i);
						next_link[h] = head;
						head = {1'b0, h};
					end
					chunks++;
				end
				if (head[HANDLE_W]) begin
					failures++;
				end else begin
					h = head[HANDLE_W-1:0];
					head = next_link[h];
					e.granted = 1'b1;
					e.block_handle = h;
					held.push_back(h);
				end
			end else begin
				e.granted = 1'b1;
				if (r.handle_present) begin
					next_link[r.release_handle] = head;
					head = {1'b0, r.release_handle};
					e.block_handle = r.release_handle;
					for (int i = 0; i < held.size(); i++) begin
						if (held[i] == r.release_handle) begin
							held.delete(i);
							break;
						end
					end
				end
			end
			grants_due.push_back(e);
		endfunction

		function void check_grant(input rsp_t got);
			rsp_t e;
			if (grants_due.size() == 0) begin
				$error("unexpected result: granted %0b, block_handle %0d", got.granted,
					got.block_handle);
				errors++;
			end else begin
				e = grants_due.pop_front();
				if (got.granted !== e.granted) begin
					$error("granted: expected %0b, actual %0b", e.granted, got.granted);
					errors++;
				end
				if (got.block_handle !== e.block_handle) begin
					$error("block_handle: expected %0d, actual %0d", e.block_handle,
						got.block_handle);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	alloc_scoreboard sb;

	fixed_block_free_list_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) sb.check_grant(result);
	end

	task automatic send_request(input req_t r);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(r);
	endtask

	task automatic program_registers(input logic [CFG_W-1:0] blocks,
			input logic [CFG_W-1:0] limit);
		cfg_valid <= 1'b1;
		cfg_index <= REG_CHUNK_BLOCKS;
		cfg_data <= blocks;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_register(REG_CHUNK_BLOCKS, blocks);
		cfg_index <= REG_CHUNK_LIMIT;
		cfg_data <= limit;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_register(REG_CHUNK_LIMIT, limit);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.grants_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int unsigned bias;
		int unsigned roll;
		logic [CFG_W-1:0] blocks;
		logic [CFG_W-1:0] limit;
		req_t r;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With a zero chunk limit only released handles can be handed out.
		program_registers(CFG_W'(1), CFG_W'(0));
		send_request('{CMD_ALLOC, 1'b1, 8'hFF});
		send_request('{CMD_RELEASE, 1'b0, 8'hFF});
		send_request('{CMD_RELEASE, 1'b1, 8'hFF});
		send_request('{CMD_RELEASE, 1'b1, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h5A});
		send_request('{CMD_ALLOC, 1'b1, 8'hA5});
		drain();

		// A zero block count behaves as one block per chunk.
		program_registers(CFG_W'(0), CFG_W'(2));
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_RELEASE, 1'b1, 8'h01});
		send_request('{CMD_RELEASE, 1'b1, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		drain();

		program_registers(CFG_W'(31), CFG_W'(31));
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		drain();

		// A double release links the same handle in twice.
		program_registers(CFG_W'(16), CFG_W'(16));
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_RELEASE, 1'b1, 8'd44});
		send_request('{CMD_RELEASE, 1'b1, 8'd44});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});
		send_request('{CMD_ALLOC, 1'b0, 8'h00});

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case ($urandom_range(4))
				0: blocks = '0;
				1: blocks = CFG_W'(1);
				2: blocks = CFG_W'(16);
				3: blocks = CFG_W'($urandom_range(17, 31));
				default: blocks = CFG_W'($urandom_range(1, 16));
			endcase
			case ($urandom_range(4))
				0: limit = '0;
				1: limit = CFG_W'(sb.chunks + 1);
				2: limit = CFG_W'(16);
				3: limit = CFG_W'($urandom_range(17, 31));
				default: limit = CFG_W'($urandom_range(1, 16));
			endcase
			program_registers(blocks, limit);
			bias = $urandom_range(35, 65);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				r.handle_present = 1'($urandom_range(1));
				r.release_handle = HANDLE_W'($urandom_range(255));
				roll = $urandom_range(99);
				if (roll < 12) begin
					r.command = CMD_RELEASE;
				end else if (roll < 12 + bias || sb.held.size() == 0) begin
					r.command = CMD_ALLOC;
				end else begin
					r.command = CMD_RELEASE;
					r.handle_present = 1'b1;
					r.release_handle = sb.held[$urandom_range(sb.held.size() - 1)];
				end
				send_request(r);
				if (p < PHASES - 1 && $urandom_range(3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 11)) @(posedge clk);
				end
			end
		end
		drain();

		$display("Covered %0d requests, %0d of them failed allocations, and %0d register writes.",
			sb.requests, sb.failures, sb.writes);
		$display("The free list grew by %0d chunks over the run.", sb.chunks);
		if (sb.grants_due.size() != 0) begin
			$error("%0d expected results never arrived", sb.grants_due.size());
		end
		if (sb.errors == 0 && sb.grants_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
